// ===== sv/ctcpd_pkg.sv =====
// ctcpd_pkg: types, character codes and sizes shared by the message deframer
// depends on nothing; used by every module of the deframer
`default_nettype none

package ctcpd_pkg;

	localparam int MaxRes = 6;
	localparam int CntW   = 3;
	localparam int QDepth = 4;

	localparam logic [7:0] CH_MQUOTE = 8'h10;
	localparam logic [7:0] CH_XQUOTE = 8'h5c;
	localparam logic [7:0] CH_XDELIM = 8'h01;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;

	localparam logic [1:0] KIND_TEXT  = 2'd0;
	localparam logic [1:0] KIND_CMD   = 2'd1;
	localparam logic [1:0] KIND_PARAM = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic [1:0] kind;
		logic       seg_end;
		logic       param_present;
		logic       msg_end;
	} out_t;

	typedef struct packed {
		out_t [MaxRes-1:0] res;
		logic [CntW-1:0]   cnt;
	} bundle_t;

endpackage

`default_nettype wire

// ===== sv/ctcp_message_deframer.sv =====
// ctcp_message_deframer: top level, front classifier, bundle queue and back sequencer
// depends on ctcpd_pkg, ctcpd_front, ctcpd_queue, ctcpd_back
//
//  channel  | handshake     | payload
//  ---------+---------------+----------------------------------------------
//  input    | push / full   | din:  data_byte, is_last
//  result   | pop / empty   | dout: out_byte, has_data, kind, seg_end,
//           |               |       param_present, msg_end
//
// one byte is taken per cycle unless full; its results, up to six, form one bundle
// a byte with no result queues nothing; each pop hands out one result
// the first result of a byte is visible once its bundle is at the queue head
// full rises when the bundle queue (QUEUE_DEPTH entries) fills; no clearing pass
// reset empties the queue and returns the quoting and segment state to plain text
`default_nettype none

module ctcp_message_deframer #(
	parameter int QUEUE_DEPTH = ctcpd_pkg::QDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire ctcpd_pkg::in_t   din,
	output logic                  empty,
	input  wire logic             pop,
	output ctcpd_pkg::out_t       dout
);

	logic               accept;
	logic               wr_en;
	ctcpd_pkg::bundle_t wr_data;
	ctcpd_pkg::bundle_t head;
	logic               head_empty;
	logic               head_pop;

	assign accept = push && !full;

	ctcpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.din     (din),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	ctcpd_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (head_pop),
		.rd_data (head),
		.empty   (head_empty)
	);

	ctcpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.dout       (dout)
	);

endmodule

`default_nettype wire

// ===== sv/ctcpd_front.sv =====
// ctcpd_front: accepts raw bytes, undoes both quoting levels and builds the
// bundle of results of one byte; depends on ctcpd_pkg
`default_nettype none

module ctcpd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire ctcpd_pkg::in_t   din,
	output logic                  wr_en,
	output ctcpd_pkg::bundle_t    wr_data
);

	typedef struct packed {
		logic       quote_pending;
		logic       backslash_pending;
		logic [1:0] segment_mode;
		logic       text_nonempty;
	} state_t;

	typedef struct packed {
		state_t             st;
		ctcpd_pkg::bundle_t b;
	} work_t;

	state_t state_q;
	work_t  w;

	function automatic work_t emit(work_t wi, logic [7:0] c, logic has, logic [1:0] k,
			logic send, logic par);
		work_t wo;
		wo = wi;
		if (wo.b.cnt < ctcpd_pkg::CntW'(ctcpd_pkg::MaxRes)) begin
			wo.b.res[wo.b.cnt] = '{out_byte: c, has_data: has, kind: k, seg_end: send,
				param_present: par, msg_end: 1'b0};
			wo.b.cnt = wo.b.cnt + 1'b1;
		end
		return wo;
	endfunction

	function automatic work_t tagged_byte(work_t wi, logic [7:0] c);
		work_t wo;
		wo = wi;
		if (wo.st.segment_mode == ctcpd_pkg::KIND_CMD && c == ctcpd_pkg::CH_SPACE) begin
			wo.st.segment_mode = ctcpd_pkg::KIND_PARAM;
		end else begin
			wo = emit(wo, c, 1'b1, wo.st.segment_mode, 1'b0, 1'b0);
		end
		return wo;
	endfunction

	function automatic work_t close_tagged(work_t wi);
		work_t wo;
		wo = emit(wi, 8'h00, 1'b0, wi.st.segment_mode, 1'b1, wi.st.segment_mode[1]);
		wo.st.segment_mode = ctcpd_pkg::KIND_TEXT;
		return wo;
	endfunction

	function automatic work_t stage_two(work_t wi, logic [7:0] c);
		work_t wo;
		logic  done;
		wo   = wi;
		done = 1'b0;
		if (wo.st.segment_mode == ctcpd_pkg::KIND_TEXT) begin
			if (c == ctcpd_pkg::CH_XDELIM) begin
				if (wo.st.text_nonempty) begin
					wo = emit(wo, 8'h00, 1'b0, ctcpd_pkg::KIND_TEXT, 1'b1, 1'b0);
				end
				wo.st.text_nonempty = 1'b0;
				wo.st.segment_mode  = ctcpd_pkg::KIND_CMD;
			end else begin
				wo = emit(wo, c, 1'b1, ctcpd_pkg::KIND_TEXT, 1'b0, 1'b0);
				wo.st.text_nonempty = 1'b1;
			end
			done = 1'b1;
		end
		if (!done && wo.st.backslash_pending) begin
			wo.st.backslash_pending = 1'b0;
			if (c == ctcpd_pkg::CH_XQUOTE) begin
				wo   = tagged_byte(wo, ctcpd_pkg::CH_XQUOTE);
				done = 1'b1;
			end else if (c == ctcpd_pkg::CH_A) begin
				wo   = tagged_byte(wo, ctcpd_pkg::CH_XDELIM);
				done = 1'b1;
			end else begin
				wo = tagged_byte(wo, ctcpd_pkg::CH_XQUOTE);
			end
		end
		if (!done) begin
			if (c == ctcpd_pkg::CH_XDELIM) begin
				wo = close_tagged(wo);
			end else if (c == ctcpd_pkg::CH_XQUOTE) begin
				wo.st.backslash_pending = 1'b1;
			end else begin
				wo = tagged_byte(wo, c);
			end
		end
		return wo;
	endfunction

	always_comb begin
		w.st = state_q;
		w.b  = '0;
		if (w.st.quote_pending) begin
			w.st.quote_pending = 1'b0;
			case (din.data_byte)
				ctcpd_pkg::CH_ZERO:   w = stage_two(w, ctcpd_pkg::CH_NUL);
				ctcpd_pkg::CH_N:      w = stage_two(w, ctcpd_pkg::CH_LF);
				ctcpd_pkg::CH_R:      w = stage_two(w, ctcpd_pkg::CH_CR);
				ctcpd_pkg::CH_MQUOTE: w = stage_two(w, ctcpd_pkg::CH_MQUOTE);
				default: begin
					w = stage_two(w, ctcpd_pkg::CH_MQUOTE);
					w = stage_two(w, din.data_byte);
				end
			endcase
		end else if (din.data_byte == ctcpd_pkg::CH_MQUOTE) begin
			w.st.quote_pending = 1'b1;
		end else begin
			w = stage_two(w, din.data_byte);
		end

		if (din.is_last) begin
			if (w.st.quote_pending) begin
				w.st.quote_pending = 1'b0;
				w = stage_two(w, ctcpd_pkg::CH_MQUOTE);
			end
			if (w.st.segment_mode != ctcpd_pkg::KIND_TEXT) begin
				if (w.st.backslash_pending) begin
					w.st.backslash_pending = 1'b0;
					w = tagged_byte(w, ctcpd_pkg::CH_XQUOTE);
				end
				w = close_tagged(w);
			end else if (w.st.text_nonempty) begin
				w = emit(w, 8'h00, 1'b0, ctcpd_pkg::KIND_TEXT, 1'b1, 1'b0);
			end
			if (w.b.cnt == '0) begin
				w = emit(w, 8'h00, 1'b0, ctcpd_pkg::KIND_TEXT, 1'b0, 1'b0);
			end
			w.b.res[w.b.cnt - 1'b1].msg_end = 1'b1;
			w.st = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= w.st;
		end
	end

	assign wr_en   = accept && (w.b.cnt != '0);
	assign wr_data = w.b;

endmodule

`default_nettype wire

// ===== sv/ctcpd_queue.sv =====
// ctcpd_queue: short queue of result bundles between front and back
// depends on ctcpd_pkg
`default_nettype none

module ctcpd_queue #(
	parameter int Depth = ctcpd_pkg::QDepth
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire ctcpd_pkg::bundle_t wr_data,
	output logic                    full,
	input  wire logic               rd_en,
	output ctcpd_pkg::bundle_t      rd_data,
	output logic                    empty
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	ctcpd_pkg::bundle_t mem [Depth];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [AW:0]        count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == (AW+1)'(Depth));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/ctcpd_back.sv =====
// ctcpd_back: walks the head bundle and hands out its results one at a time
// depends on ctcpd_pkg
`default_nettype none

module ctcpd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctcpd_pkg::bundle_t head,
	input  wire logic               head_empty,
	output logic                    head_pop,
	input  wire logic               pop,
	output logic                    empty,
	output ctcpd_pkg::out_t         dout
);

	logic [ctcpd_pkg::CntW-1:0] idx_q;
	logic                       take;
	logic                       at_last;

	assign empty    = head_empty;
	assign dout     = head.res[idx_q];
	assign take     = pop && !head_empty;
	assign at_last  = (idx_q == head.cnt - 1'b1);
	assign head_pop = take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= at_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire
